// ----- rtl/can_bit_timing_search_defines.svh -----
// Assertion macros used by the checker of the bit timing search block.
// No dependencies; include with the bare file name.
`ifndef CAN_BIT_TIMING_SEARCH_DEFINES_SVH
`define CAN_BIT_TIMING_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define CBTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbts assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define CBTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbts assertion failed");

`endif

// ----- rtl/cbts_pkg.sv -----
// Package for the CAN bit timing search: widths, search limits, sequencer states.
// No dependencies.
package cbts_pkg;

  localparam int unsigned ClkW   = 32;  // main clock register width
  localparam int unsigned BaudW  = 20;  // requested bit rate width
  localparam int unsigned DivW   = 4;   // prescaler width
  localparam int unsigned WordW  = 15;  // packed timing word width
  localparam int unsigned StepW  = 10;  // quanta * (divider + 1), at most 512
  localparam int unsigned AccW   = 14;  // segments * step, at most 8704
  localparam int unsigned CntW   = 5;   // divider bit counter

  localparam logic [DivW-1:0] DivMax      = 4'd15;
  localparam logic [4:0]      QuantaLast  = 5'd31;  // quanta - 1 at its top value
  localparam logic [4:0]      SegsMin     = 5'd3;
  localparam logic [4:0]      SegsMax     = 5'd17;
  localparam logic [ClkW-1:0] MainClkRst  = 32'd48000000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEARCH
  } cbts_state_e;

endpackage

// ----- rtl/can_bit_timing_search.sv -----
// A zero bit rate is answered from idle; otherwise the divider runs, the first candidate
// is loaded and the search steps through the candidates, up to 7680 of them.
// One request at a time; busy is high during divide and search, never for a zero rate.
// The search rate is set by the single accumulate-and-compare unit, one candidate a cycle.
// Reset: sequencer idle, no result pending, main clock register 48000000.
// The result strobe lasts one cycle; the receiver cannot stall.
module can_bit_timing_search
  import cbts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [BaudW-1:0] baud_rate_i,
  output logic             done_o,
  output logic             found_o,
  output logic [DivW-1:0]  clock_divider_o,
  output logic [WordW-1:0] timing_word_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [ClkW-1:0]  cfg_data_i
);

  cbts_state_e state_q, state_d;

  logic [ClkW-1:0]  main_clk_q;
  logic [ClkW-1:0]  cpb_q;
  logic [DivW-1:0]  d_q, d_d;
  logic [4:0]       q_q, q_d;     // quanta - 1
  logic [4:0]       s_q, s_d;     // segment total
  logic [StepW-1:0] step_q, step_d;
  logic [AccW-1:0]  acc_q, acc_d;

  logic             done_q, done_d;
  logic             found_q, found_d;
  logic [DivW-1:0]  cdiv_q, cdiv_d;
  logic [WordW-1:0] word_q, word_d;

  logic             accept;
  logic             div_start;
  logic             div_done;
  logic [ClkW-1:0]  div_quo;
  logic             hit;
  logic             s_last, q_last, d_last;
  logic [StepW-1:0] step_nq, step_nd;
  logic [3:0]       rest;
  logic [2:0]       seg1, seg2;
  logic [1:0]       sjw;
  logic [WordW-1:0] word_hit;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Main clock register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_clk_q <= MainClkRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      main_clk_q <= cfg_data_i;
    end
  end

  // Clocks per bit from the serial divider
  cbts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (main_clk_q),
    .divisor_i  (baud_rate_i),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Compare unit and loop ends
  assign hit     = ({{(ClkW-AccW){1'b0}}, acc_q} == cpb_q);
  assign s_last  = (s_q == SegsMax);
  assign q_last  = (q_q == QuantaLast);
  assign d_last  = (d_q == DivMax);
  assign step_nq = step_q + {{(StepW-DivW){1'b0}}, d_q} + StepW'(1);
  assign step_nd = {{(StepW-DivW){1'b0}}, d_q} + StepW'(2);

  // Split the spare segments and pack the timing word
  assign rest     = s_q[3:0] - SegsMin[3:0];
  assign seg1     = rest[3:1];
  assign seg2     = 3'(rest - {1'b0, seg1});
  assign sjw      = (seg1 > 3'd3) ? 2'd3 : seg1[1:0];
  assign word_hit = {seg2, 1'b0, seg1, sjw, 1'b0, q_q};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (baud_rate_i != '0)) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (hit || (s_last && q_last && d_last)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and search stepping
  always_comb begin
    div_start = 1'b0;
    done_d    = 1'b0;
    found_d   = found_q;
    cdiv_d    = cdiv_q;
    word_d    = word_q;
    d_d       = d_q;
    q_d       = q_q;
    s_d       = s_q;
    step_d    = step_q;
    acc_d     = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (baud_rate_i == '0) begin
            done_d  = 1'b1;
            found_d = 1'b0;
            cdiv_d  = '0;
            word_d  = '0;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        // Load the first candidate: divider 0, one quantum, three segments
        d_d    = '0;
        q_d    = '0;
        s_d    = SegsMin;
        step_d = StepW'(1);
        acc_d  = AccW'(3);
      end
      ST_SEARCH: begin
        if (hit) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          cdiv_d  = d_q;
          word_d  = word_hit;
        end else if (s_last) begin
          s_d = SegsMin;
          if (q_last) begin
            if (d_last) begin
              done_d  = 1'b1;
              found_d = 1'b0;
              cdiv_d  = '0;
              word_d  = '0;
            end else begin
              d_d    = d_q + 1'b1;
              q_d    = '0;
              step_d = step_nd;
              acc_d  = {step_nd, 1'b0} + {{(AccW-StepW){1'b0}}, step_nd};
            end
          end else begin
            q_d    = q_q + 1'b1;
            step_d = step_nq;
            acc_d  = {step_nq, 1'b0} + {{(AccW-StepW){1'b0}}, step_nq};
          end
        end else begin
          s_d   = s_q + 1'b1;
          acc_d = acc_q + {{(AccW-StepW){1'b0}}, step_q};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Search and result payload
  always_ff @(posedge clk_i) begin
    if (div_done) cpb_q <= div_quo;
    d_q     <= d_d;
    q_q     <= q_d;
    s_q     <= s_d;
    step_q  <= step_d;
    acc_q   <= acc_d;
    found_q <= found_d;
    cdiv_q  <= cdiv_d;
    word_q  <= word_d;
  end

  assign done_o          = done_q;
  assign found_o         = found_q;
  assign clock_divider_o = cdiv_q;
  assign timing_word_o   = word_q;

endmodule

// ----- rtl/cbts_div.sv -----
// Restoring divider, one quotient bit per cycle, for the bit timing search.
// Depends on cbts_pkg.
module cbts_div
  import cbts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ClkW-1:0]  dividend_i,
  input  logic [BaudW-1:0] divisor_i,
  output logic             done_o,
  output logic [ClkW-1:0]  quotient_o
);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ClkW-1:0]  quo_q, quo_d;
  logic [BaudW-1:0] rem_q, rem_d;
  logic [BaudW-1:0] dvs_q, dvs_d;
  logic [BaudW:0]   trial;
  logic [BaudW:0]   diff;
  logic             ge;

  // Shift the next dividend bit in and try one subtract
  assign trial = {rem_q, quo_q[ClkW-1]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      quo_d = {quo_q[ClkW-2:0], ge};
      rem_d = ge ? diff[BaudW-1:0] : trial[BaudW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control in reset flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/cbts_chk.sv -----
// Port-level checker for the CAN bit timing search, bound to the top level.
// Depends on cbts_pkg and can_bit_timing_search_defines.svh.
`include "can_bit_timing_search_defines.svh"

module cbts_chk
  import cbts_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [BaudW-1:0] baud_rate_i,
  input logic             done_o,
  input logic             found_o,
  input logic [DivW-1:0]  clock_divider_o,
  input logic [WordW-1:0] timing_word_o
);

  // A result always leaves the block idle
  `CBTS_ASSERT_IMP(a_done_idle, done_o, !busy)

  // A zero rate answers not found in the next cycle
  `CBTS_ASSERT_NXT(a_zero_rate, start && !busy && (baud_rate_i == '0), done_o && !found_o)

  // A non-zero rate starts a search
  `CBTS_ASSERT_NXT(a_rate_busy, start && !busy && (baud_rate_i != '0), busy && !done_o)

  // A miss carries all-zero fields
  `CBTS_ASSERT_IMP(a_miss_zero, done_o && !found_o,
                   (clock_divider_o == '0) && (timing_word_o == '0))

endmodule

bind can_bit_timing_search cbts_chk u_cbts_chk (.*);

// ----- dv/tb_can_bit_timing_search.sv -----
// Testbench for can_bit_timing_search: directed tables then random bit rate requests,
// each result checked against a known value or a local divider/quanta/segment search.
// Depends on rtl/cbts_pkg.sv and rtl/can_bit_timing_search.sv.
module tb_can_bit_timing_search;
  import cbts_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned RandomPhases = 5;
  localparam int unsigned ItemsPerPhase = 20;

  typedef struct packed {
    logic             found;
    logic [DivW-1:0]  divider;
    logic [WordW-1:0] word;
  } timing_t;

  // One row of the directed plan: either a main clock write or a bit rate request
  typedef struct {
    bit              is_clock_write;
    logic [ClkW-1:0] value;
    bit              has_known;
    timing_t         known;
  } plan_row_t;

  localparam timing_t NotFound = '0;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [BaudW-1:0] baud_rate_i = '0;
  logic             done_o;
  logic             found_o;
  logic [DivW-1:0]  clock_divider_o;
  logic [WordW-1:0] timing_word_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [ClkW-1:0]  cfg_data_i = '0;

  logic [ClkW-1:0]  main_clock_model = MainClkRst;
  timing_t          pending_timing_q[$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;
  int               burst_left = 0;

  plan_row_t directed_plan[17] = '{
    '{1'b0, 32'd0,          1'b1, NotFound},
    '{1'b0, 32'd1,          1'b1, NotFound},
    '{1'b0, 32'hFFFFF,      1'b0, NotFound},
    '{1'b0, 32'd1000000,    1'b0, NotFound},
    '{1'b0, 32'd500000,     1'b0, NotFound},
    '{1'b0, 32'd250000,     1'b0, NotFound},
    '{1'b0, 32'd125000,     1'b0, NotFound},
    '{1'b0, 32'd100000,     1'b0, NotFound},
    '{1'b0, 32'h55555,      1'b0, NotFound},
    '{1'b0, 32'hAAAAA,      1'b0, NotFound},
    '{1'b1, 32'd0,          1'b0, NotFound},
    '{1'b0, 32'd1000000,    1'b1, NotFound},
    '{1'b0, 32'd0,          1'b1, NotFound},
    '{1'b1, 32'hFFFFFFFF,   1'b0, NotFound},
    '{1'b0, 32'd1,          1'b1, NotFound},
    '{1'b0, 32'hFFFFF,      1'b0, NotFound},
    '{1'b1, 32'd3,          1'b0, NotFound}
  };

  // Smallest and largest matching products and one rate below the smallest, checked by value
  plan_row_t corner_plan[4] = '{
    '{1'b0, 32'd1,          1'b1, '{1'b1, 4'd0, 15'h0000}},
    '{1'b0, 32'd2,          1'b1, NotFound},
    '{1'b1, 32'd8704,       1'b0, NotFound},
    '{1'b0, 32'd1,          1'b1, '{1'b1, 4'd15, 15'h77DF}}
  };

  can_bit_timing_search u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .baud_rate_i     (baud_rate_i),
    .done_o          (done_o),
    .found_o         (found_o),
    .clock_divider_o (clock_divider_o),
    .timing_word_o   (timing_word_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Search divider, quanta and segments in order for the first exact clocks-per-bit match
  function automatic timing_t search_timing(input logic [ClkW-1:0] clk_hz,
                                            input logic [BaudW-1:0] baud);
    timing_t         res;
    logic [ClkW-1:0] per_bit;
    int unsigned     rest;
    int unsigned     seg1;
    int unsigned     seg2;
    int unsigned     sjw;
    res = '0;
    if (baud == '0) return res;
    per_bit = clk_hz / {{(ClkW-BaudW){1'b0}}, baud};
    for (int unsigned d = 0; d <= 15; d++) begin
      for (int unsigned q = 1; q <= 32; q++) begin
        for (int unsigned s = 3; s <= 17; s++) begin
          if (per_bit == s * q * (d + 1)) begin
            rest = s - 3;
            seg1 = rest / 2;
            seg2 = rest - seg1;
            sjw = (seg1 > 3) ? 3 : seg1;
            res.found = 1'b1;
            res.divider = 4'(d);
            res.word = {3'(seg2), 4'(seg1), 2'(sjw), 6'(q - 1)};
            return res;
          end
        end
      end
    end
    return res;
  endfunction

  // Mostly rates that land on a product of the search, the rest anywhere in the field
  function automatic logic [BaudW-1:0] pick_baud(input logic [ClkW-1:0] clk_hz);
    int unsigned     sel;
    int unsigned     product;
    logic [ClkW-1:0] rate;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      product = $urandom_range(3, 17) * $urandom_range(1, 32) * ($urandom_range(0, 15) + 1);
      rate = clk_hz / product;
      if (rate == '0 || rate > 32'hFFFFF) rate = $urandom_range(1, 1000000);
      return rate[BaudW-1:0];
    end
    if (sel < 85) return BaudW'($urandom_range(0, 1000000));
    return BaudW'($urandom);
  endfunction

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
  endfunction

  function automatic void note_mismatch(input string what, input timing_t want,
                                        input timing_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d: %s: expected found=%0d div=%0d word=%h, got found=%0d div=%0d word=%h",
               mismatch_count, what, want.found, want.divider, want.word,
               got.found, got.divider, got.word);
  endfunction

  // Present a request after a random gap; start stays high until the next one or a quiesce
  task automatic issue_request(input logic [BaudW-1:0] baud, input bit has_known,
                               input timing_t known);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    baud_rate_i <= baud;
    do @(posedge clk_i); while (busy);
    pending_timing_q.push_back(has_known ? known : search_timing(main_clock_model, baud));
  endtask

  // Drop start, let every result arrive, then write the main clock register
  task automatic write_main_clock(input logic [ClkW-1:0] clk_hz);
    start <= 1'b0;
    while (pending_timing_q.size() != 0 || busy) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= clk_hz;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    main_clock_model = clk_hz;
  endtask

  task automatic run_plan_row(input plan_row_t row);
    if (row.is_clock_write) write_main_clock(row.value);
    else issue_request(row.value[BaudW-1:0], row.has_known, row.known);
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk_i) begin
    timing_t got;
    timing_t want;
    got = {found_o, clock_divider_o, timing_word_o};
    if (rst_ni && done_o) begin
      if (pending_timing_q.size() == 0) begin
        note_mismatch("unexpected result", NotFound, got);
      end else begin
        want = pending_timing_q.pop_front();
        if (want !== got) note_mismatch("result", want, got);
      end
    end
  end

  // Stop a run that overstays the cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [ClkW-1:0] phase_clock;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset clock, zero and full clock, smallest and largest product
    foreach (directed_plan[i]) run_plan_row(directed_plan[i]);
    foreach (corner_plan[i]) run_plan_row(corner_plan[i]);

    // Random part over several clock settings
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: phase_clock = 32'd48000000;
        1: phase_clock = $urandom_range(3, 65535);
        2: phase_clock = 32'd24000000;
        3: phase_clock = $urandom;
        default: phase_clock = 32'd8000000;
      endcase
      write_main_clock(phase_clock);
      for (int n = 0; n < ItemsPerPhase; n++)
        issue_request(pick_baud(main_clock_model), 1'b0, NotFound);
    end
    start <= 1'b0;

    // Wait for outstanding results, then watch for strays
    while (pending_timing_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_timing_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
